### rtl/iatt_pkg.sv
package iatt_pkg;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_THR_LOW    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THR_HIGH   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CURVE_0    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CURVE_1    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CURVE_2    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CURVE_3    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CURVE_SEL  = 3'd6;

   // Register reset values
   localparam logic [CSR_DATA_BITS-1:0] RESET_THR_LOW  = 64'd27021941366128700;
   localparam logic [CSR_DATA_BITS-1:0] RESET_THR_HIGH = 64'd135109019623751800;
   localparam logic [CSR_DATA_BITS-1:0] RESET_CURVE_0  = 64'd27692722414576226;
   localparam logic [CSR_DATA_BITS-1:0] RESET_CURVE_1  = 64'd1428481279474750;
   localparam logic [CSR_DATA_BITS-1:0] RESET_CURVE_2  = 64'd5119537468291386;
   localparam logic [CSR_DATA_BITS-1:0] RESET_CURVE_3  = 64'd5119537502569540;

   // Field layout
   localparam int SLOT_BITS     = 16;
   localparam int SLOTS_PER_REG = 4;
   localparam int NUM_THR       = 8;
   localparam int NUM_CURVES    = 4;
   localparam int CURVE_SEL_BITS = 2;
   localparam int BAND_BITS     = 3;
   localparam int PCT_BITS      = 7;
   localparam int BYTE_BITS     = 8;
   localparam int PERIOD_BITS   = 13;

   localparam logic [PCT_BITS-1:0] PERCENT_FULL = 7'd100;
   localparam logic [BAND_BITS-1:0] BAND_SLOWEST = 3'd7;

   typedef logic [BAND_BITS-1:0] band_type;
   typedef logic [PCT_BITS-1:0]  pct_type;

endpackage

### rtl/iatt_req_if.sv
interface iatt_req_if;
   logic valid;
   logic ready;
   logic sensor_level;

   modport source (output valid, output sensor_level, input ready);
   modport sink   (input valid, input sensor_level, output ready);
endinterface

### rtl/iatt_rsp_if.sv
interface iatt_rsp_if
   import iatt_pkg::*;
;
   logic                   valid;
   logic                   ready;
   logic                   spark;
   logic                   revolution;
   logic [BAND_BITS-1:0]   speed_band;
   logic [PERIOD_BITS-1:0] last_period;

   modport source (output valid, output spark, output revolution, output speed_band,
                   output last_period, input ready);
   modport sink   (input valid, input spark, input revolution, input speed_band,
                   input last_period, output ready);
endinterface

### rtl/iatt_cut.sv
// Band search over seven thresholds and the percentage cut of the count.
// floor(count * pct / 100) is formed as (count * ceil(pct * 2^S / 100)) >> S,
// exact for every count below 2^CNT_BITS when S = CNT_BITS + 7.
module iatt_cut
   import iatt_pkg::*;
#(
   parameter int THRESHOLD_BITS = 12
) (
   input  logic [THRESHOLD_BITS:0]   count,
   input  logic [THRESHOLD_BITS-1:0] thresholds [0:NUM_THR-2],
   input  logic [CSR_DATA_BITS-1:0]  curve,
   output band_type                  band,
   output logic [THRESHOLD_BITS:0]   count_cut
);

   localparam int CNT_BITS    = THRESHOLD_BITS + 1;
   localparam int RECIP_SHIFT = CNT_BITS + PCT_BITS;
   localparam int RECIP_BITS  = RECIP_SHIFT + 1;
   localparam int PROD_BITS   = CNT_BITS + RECIP_BITS;
   localparam int PCT_ENTRIES = 1 << PCT_BITS;

   typedef logic [RECIP_BITS-1:0] recip_table_type [0:PCT_ENTRIES-1];

   function automatic recip_table_type make_recip();
      recip_table_type t;
      for (int i = 0; i < PCT_ENTRIES; i++) begin
         t[i] = RECIP_BITS'(((64'(i) << RECIP_SHIFT) + 64'd99) / 64'd100);
      end
      return t;
   endfunction

   localparam recip_table_type RECIP = make_recip();

   logic [NUM_THR-2:0]     above;
   logic [BYTE_BITS-1:0]   pct_raw;
   pct_type                pct;
   logic [RECIP_BITS-1:0]  recip;
   logic [PROD_BITS-1:0]   product;
   logic [CNT_BITS-1:0]    cut;

   always_comb begin
      for (int k = 0; k < NUM_THR - 1; k++) begin
         above[k] = count > {1'b0, thresholds[k]};
      end
   end

   // Same decision order as a binary search: middle threshold first.
   always_comb begin
      if (above[3]) begin
         if (above[5]) band = above[6] ? 3'd7 : 3'd6;
         else          band = above[4] ? 3'd5 : 3'd4;
      end else begin
         if (above[1]) band = above[2] ? 3'd3 : 3'd2;
         else          band = above[0] ? 3'd1 : 3'd0;
      end
   end

   assign pct_raw   = curve[{band, 3'b000} +: BYTE_BITS];
   assign pct       = (pct_raw > {1'b0, PERCENT_FULL}) ? PERCENT_FULL : pct_raw[PCT_BITS-1:0];
   assign recip     = RECIP[pct];
   assign product   = PROD_BITS'(count) * PROD_BITS'(recip);
   assign cut       = product[RECIP_SHIFT +: CNT_BITS];
   assign count_cut = count - cut;

endmodule

### rtl/ignition_advance_tick_timer.sv
// Channel   | Role   | Payload                                           | Beat
// req_chan  | sink   | sensor_level                                      | one timer tick
// rsp_chan  | source | spark, revolution, speed_band, last_period        | one per tick
// csr_*     | write  | csr_index selects register, csr_wdata 64 bits     | one write
//
// Every tick passes through the input register, then through the band
// compare, curve lookup and reciprocal multiply into the result register.
// A tick is accepted every cycle unless a stalled result holds the input.
// Reset is synchronous and restores all state but the input level to defaults.
// A stalled result holds the input register until the result is taken.
module ignition_advance_tick_timer
   import iatt_pkg::*;
#(
   parameter int THRESHOLD_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   iatt_req_if.sink                   req_chan,
   iatt_rsp_if.source                 rsp_chan,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int CNT_BITS    = THRESHOLD_BITS + 1;
   localparam int PERIOD_WIDE = (CNT_BITS > PERIOD_BITS) ? CNT_BITS : PERIOD_BITS;

   // Configuration registers
   logic [THRESHOLD_BITS-1:0] thr_ff   [0:NUM_THR-1];
   logic [CSR_DATA_BITS-1:0]  curve_ff [0:NUM_CURVES-1];
   logic [CURVE_SEL_BITS-1:0] curve_sel_ff;

   // Input stage
   logic in_valid_ff;
   logic level_ff;

   // Block state, which doubles as the result register
   logic                out_valid_ff;
   logic                prev_ff,   prev_in;
   logic [CNT_BITS-1:0] count_ff,  count_in;
   band_type            band_ff,   band_in;
   logic                spark_ff,  spark_in;
   logic [CNT_BITS-1:0] period_ff, period_in;
   logic                rev_ff,    rev_in;

   logic                      advance;
   logic [CNT_BITS-1:0]       limit;
   logic [THRESHOLD_BITS-1:0] thr_band [0:NUM_THR-2];
   band_type                  band_new;
   logic [CNT_BITS-1:0]       count_cut;
   logic [PERIOD_WIDE-1:0]    period_wide;

   // ---------------------------------------------------------------
   // Configuration writes; only the low THRESHOLD_BITS of each slot matter
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLOTS_PER_REG; k++) begin
            thr_ff[k]                 <= RESET_THR_LOW[k*SLOT_BITS +: THRESHOLD_BITS];
            thr_ff[k + SLOTS_PER_REG] <= RESET_THR_HIGH[k*SLOT_BITS +: THRESHOLD_BITS];
         end
         curve_ff[0]  <= RESET_CURVE_0;
         curve_ff[1]  <= RESET_CURVE_1;
         curve_ff[2]  <= RESET_CURVE_2;
         curve_ff[3]  <= RESET_CURVE_3;
         curve_sel_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THR_LOW: begin
               for (int k = 0; k < SLOTS_PER_REG; k++) begin
                  thr_ff[k] <= csr_wdata[k*SLOT_BITS +: THRESHOLD_BITS];
               end
            end
            CSR_THR_HIGH: begin
               for (int k = 0; k < SLOTS_PER_REG; k++) begin
                  thr_ff[k + SLOTS_PER_REG] <= csr_wdata[k*SLOT_BITS +: THRESHOLD_BITS];
               end
            end
            CSR_CURVE_0:   curve_ff[0]  <= csr_wdata;
            CSR_CURVE_1:   curve_ff[1]  <= csr_wdata;
            CSR_CURVE_2:   curve_ff[2]  <= csr_wdata;
            CSR_CURVE_3:   curve_ff[3]  <= csr_wdata;
            CSR_CURVE_SEL: curve_sel_ff <= csr_wdata[CURVE_SEL_BITS-1:0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake: advance the held tick whenever the result slot frees up
   // ---------------------------------------------------------------
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         level_ff <= req_chan.sensor_level;
      end
   end

   // ---------------------------------------------------------------
   // Band search and percentage cut
   // ---------------------------------------------------------------
   always_comb begin
      for (int k = 0; k < NUM_THR - 1; k++) begin
         thr_band[k] = thr_ff[k];
      end
   end

   iatt_cut #(
      .THRESHOLD_BITS (THRESHOLD_BITS)
   ) u_cut (
      .count      (count_ff),
      .thresholds (thr_band),
      .curve      (curve_ff[curve_sel_ff]),
      .band       (band_new),
      .count_cut  (count_cut)
   );

   // Counter saturates at twice the top threshold
   assign limit = {thr_ff[NUM_THR-1], 1'b0};

   // ---------------------------------------------------------------
   // Next state for one tick
   // ---------------------------------------------------------------
   always_comb begin
      prev_in   = level_ff;
      count_in  = count_ff;
      band_in   = band_ff;
      spark_in  = spark_ff;
      period_in = period_ff;
      rev_in    = 1'b0;
      if (level_ff == prev_ff) begin
         // level held: count up while high, down while low
         if (level_ff) begin
            if (count_ff < limit) count_in = count_ff + 1'b1;
            else                  spark_in = 1'b0;
         end else begin
            if (count_ff != '0)   count_in = count_ff - 1'b1;
            else                  spark_in = 1'b0;
         end
      end else if (count_ff == '0) begin
         // edge with an expired count: fire
         spark_in = 1'b1;
         rev_in   = 1'b1;
      end else begin
         // edge with a live count: classify speed and shorten the count
         band_in   = band_new;
         period_in = count_ff;
         count_in  = count_cut;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         prev_ff      <= 1'b0;
         count_ff     <= '0;
         band_ff      <= BAND_SLOWEST;
         spark_ff     <= 1'b0;
         period_ff    <= '0;
         rev_ff       <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            prev_ff      <= prev_in;
            count_ff     <= count_in;
            band_ff      <= band_in;
            spark_ff     <= spark_in;
            period_ff    <= period_in;
            rev_ff       <= rev_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Result beat straight from the state registers
   // ---------------------------------------------------------------
   assign period_wide          = PERIOD_WIDE'(period_ff);
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.spark       = spark_ff;
   assign rsp_chan.revolution  = rev_ff;
   assign rsp_chan.speed_band  = band_ff;
   assign rsp_chan.last_period = period_wide[PERIOD_BITS-1:0];

endmodule

### rtl/iatt_checker.sv
module iatt_checker
   import iatt_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_spark,
   input logic                   rsp_revolution,
   input logic [BAND_BITS-1:0]   rsp_speed_band,
   input logic [PERIOD_BITS-1:0] rsp_last_period
);

   // A fired tick always leaves the coil driven
   a_rev_spark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_revolution |-> rsp_spark)
      else $error("revolution beat without spark");

   // Input backs up only when the result side is stalled
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while result side is free");

   // A fresh result follows from a tick accepted into the input register before it
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a matching tick");

   // Stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_spark)
         && $stable(rsp_revolution) && $stable(rsp_speed_band)
         && $stable(rsp_last_period))
      else $error("stalled result changed");

endmodule

bind ignition_advance_tick_timer iatt_checker u_iatt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_spark       (rsp_chan.spark),
   .rsp_revolution  (rsp_chan.revolution),
   .rsp_speed_band  (rsp_chan.speed_band),
   .rsp_last_period (rsp_chan.last_period)
);

### tb/ignition_advance_tick_timer_tb.sv
module ignition_advance_tick_timer_tb;
   import iatt_pkg::*;

   localparam int THRESHOLD_BITS = 12;
   localparam int THR_MASK       = (1 << THRESHOLD_BITS) - 1;
   // Two pipeline stages plus some slack before touching the registers.
   localparam int LATENCY_CYCLES = 4;
   // Longest quiet stretch of a correct run is a handful of register writes.
   localparam int WATCHDOG_LIMIT = 200;
   // Index 7 is past the register list and must be ignored.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic                   spark;
      logic                   revolution;
      band_type               speed_band;
      logic [PERIOD_BITS-1:0] last_period;
   } tick_result_type;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
      logic                      level;
      logic                      pinned;
      tick_result_type           result;
   } stim_row_type;

   typedef enum logic [1:0] {PH_ZERO_THR, PH_SMALL_THR, PH_WIDE_THR, PH_RESET_CFG} phase_kind_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   iatt_req_if req_chan ();
   iatt_rsp_if rsp_chan ();

   ignition_advance_tick_timer #(
      .THRESHOLD_BITS(THRESHOLD_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Timer predictor: shadow registers plus the per-tick state of the block.
   // ---------------------------------------------------------------------------
   logic [CSR_DATA_BITS-1:0]  thr_lo_cfg = RESET_THR_LOW;
   logic [CSR_DATA_BITS-1:0]  thr_hi_cfg = RESET_THR_HIGH;
   logic [CSR_DATA_BITS-1:0]  curve_cfg [NUM_CURVES] =
      '{RESET_CURVE_0, RESET_CURVE_1, RESET_CURVE_2, RESET_CURVE_3};
   logic [CURVE_SEL_BITS-1:0] curve_sel_cfg = '0;

   logic                      level_q  = 1'b0;
   int                        count_q  = 0;
   band_type                  band_q   = BAND_SLOWEST;
   logic                      spark_q  = 1'b0;
   logic [PERIOD_BITS-1:0]    period_q = '0;

   tick_result_type           expected_ticks [$];
   stim_row_type              directed_rows [$];
   logic                      failed      = 1'b0;
   logic                      no_idle     = 1'b0;
   logic                      drive_level = 1'b0;
   logic                      pin_en      = 1'b0;
   tick_result_type           pin_result  = '0;
   int                        stalled_cycles = 0;

   // Pull threshold k out of its 16-bit slot; only the low THRESHOLD_BITS count.
   function automatic int threshold_of(int k);
      logic [CSR_DATA_BITS-1:0] bank;
      bank = (k < SLOTS_PER_REG) ? thr_lo_cfg : thr_hi_cfg;
      return int'((bank >> ((k % SLOTS_PER_REG) * SLOT_BITS)) & CSR_DATA_BITS'(THR_MASK));
   endfunction

   // Same compare tree as the hardware, so unordered thresholds land the same way.
   function automatic band_type band_of(int n);
      if (n > threshold_of(3)) begin
         if (n > threshold_of(5))
            return (n > threshold_of(6)) ? band_type'(7) : band_type'(6);
         return (n > threshold_of(4)) ? band_type'(5) : band_type'(4);
      end
      if (n > threshold_of(1))
         return (n > threshold_of(2)) ? band_type'(3) : band_type'(2);
      return (n > threshold_of(0)) ? band_type'(1) : band_type'(0);
   endfunction

   function automatic tick_result_type advance_tick(logic lvl);
      tick_result_type r;
      int              pct;
      logic            fired;
      fired = 1'b0;
      if (lvl == level_q) begin
         // Steady level: count up while high up to the limit, down while low.
         // A counter that cannot move drops the spark.
         if (lvl) begin
            if (count_q < 2 * threshold_of(NUM_THR - 1))
               count_q++;
            else
               spark_q = 1'b0;
         end else if (count_q > 0) begin
            count_q--;
         end else begin
            spark_q = 1'b0;
         end
      end else if (count_q == 0) begin
         spark_q = 1'b1;
         fired   = 1'b1;
      end else begin
         // Edge with a live count: pick the band, capture, cut by the curve.
         band_q   = band_of(count_q);
         period_q = PERIOD_BITS'(count_q);
         pct = int'((curve_cfg[curve_sel_cfg] >> (band_q * BYTE_BITS)) & 64'hFF);
         if (pct > int'(PERCENT_FULL))
            pct = int'(PERCENT_FULL);
         count_q = count_q - (count_q * pct) / int'(PERCENT_FULL);
      end
      level_q = lvl;
      r.spark       = spark_q;
      r.revolution  = fired;
      r.speed_band  = band_q;
      r.last_period = period_q;
      return r;
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_BITS-1:0] idx,
                                     logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_THR_LOW:   thr_lo_cfg = data;
         CSR_THR_HIGH:  thr_hi_cfg = data;
         CSR_CURVE_0:   curve_cfg[0] = data;
         CSR_CURVE_1:   curve_cfg[1] = data;
         CSR_CURVE_2:   curve_cfg[2] = data;
         CSR_CURVE_3:   curve_cfg[3] = data;
         CSR_CURVE_SEL: curve_sel_cfg = data[CURVE_SEL_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failed = 1'b1;
      end
   endfunction

   function automatic int idle_draw();
      return no_idle ? 0 : int'($urandom_range(0, 3));
   endfunction

   // Table row builders.
   function automatic stim_row_type tick_row(logic lvl);
      return '{ROW_TICK, '0, '0, lvl, 1'b0, '0};
   endfunction

   function automatic stim_row_type pinned_row(logic lvl, tick_result_type res);
      return '{ROW_TICK, '0, '0, lvl, 1'b1, res};
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_INDEX_BITS-1:0] idx,
                                            logic [CSR_DATA_BITS-1:0] data);
      return '{ROW_CSR, idx, data, 1'b0, 1'b0, '0};
   endfunction

   // ---------------------------------------------------------------------------
   // Monitor: predict on every accepted tick, check every result beat in order.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      tick_result_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            want = advance_tick(req_chan.sensor_level);
            // Typed-in rows override the predictor but still advance it.
            if (pin_en)
               want = pin_result;
            expected_ticks.push_back(want);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_ticks.size() == 0) begin
               $error("result beat with no tick outstanding");
               failed = 1'b1;
            end else begin
               want = expected_ticks.pop_front();
               check_field("spark", want.spark, rsp_chan.spark);
               check_field("revolution", want.revolution, rsp_chan.revolution);
               check_field("speed_band", want.speed_band, rsp_chan.speed_band);
               check_field("last_period", want.last_period, rsp_chan.last_period);
            end
         end
      end
   end

   // Watchdog: give up when neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("ignition_advance_tick_timer verification failed");
         $finish;
      end
   end

   // Result side: stall a random number of cycles before taking each beat.
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      while (reset)
         @(negedge clock);
      forever begin
         stall = idle_draw();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_chan.valid && rsp_chan.ready))
            @(posedge clock);
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------------
   // Tick side. Every task starts and ends on a falling edge.
   // ---------------------------------------------------------------------------
   task automatic send_tick(logic lvl, logic pinned, tick_result_type pinned_result);
      int gap;
      gap = idle_draw();
      // Close any register write left open by the previous step.
      csr_we <= 1'b0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.sensor_level <= lvl;
      pin_en                <= pinned;
      pin_result            <= pinned_result;
      drive_level = lvl;
      @(posedge clock);
      while (!(req_chan.valid && req_chan.ready))
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic emit_run(logic lvl, int len);
      repeat (len) send_tick(lvl, 1'b0, '0);
   endtask

   // Drop valid, drain every outstanding result, then let the pipe settle.
   task automatic quiesce();
      req_chan.valid <= 1'b0;
      csr_we         <= 1'b0;
      while (expected_ticks.size() != 0)
         @(negedge clock);
      repeat (LATENCY_CYCLES) @(negedge clock);
   endtask

   // Leaves the write enable high; the next step lowers it.
   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_csr(idx, data);
      @(negedge clock);
   endtask

   initial begin
      phase_kind_type           phase_plan [8] = '{PH_ZERO_THR, PH_SMALL_THR, PH_SMALL_THR,
                                                   PH_SMALL_THR, PH_WIDE_THR, PH_SMALL_THR,
                                                   PH_SMALL_THR, PH_RESET_CFG};
      phase_kind_type           kind;
      int                       thr [NUM_THR];
      logic [CSR_DATA_BITS-1:0] bank [2];
      logic [CSR_DATA_BITS-1:0] curve_word [NUM_CURVES];
      logic [CSR_DATA_BITS-1:0] sel_word;
      logic [SLOT_BITS-1:0]     slot;
      int                       acc, budget, scale, sent, len;
      logic                     sorted;

      req_chan.valid        <= 1'b0;
      req_chan.sensor_level <= 1'b0;

      // Directed table. Only the first rows out of reset are typed in; the
      // rest are left to the predictor.
      directed_rows.push_back(pinned_row(1'b0, '{1'b0, 1'b0, BAND_SLOWEST, '0}));
      directed_rows.push_back(pinned_row(1'b1, '{1'b1, 1'b1, BAND_SLOWEST, '0}));
      directed_rows.push_back(pinned_row(1'b1, '{1'b1, 1'b0, BAND_SLOWEST, '0}));
      // Edge with a count of one under the reset curve.
      directed_rows.push_back(tick_row(1'b0));
      // Write past the register list: must change nothing.
      directed_rows.push_back(csr_row(CSR_UNUSED, '1));
      // Thresholds 0..6, limit 6; junk in the unused top bits of each slot.
      directed_rows.push_back(csr_row(CSR_THR_LOW, 64'hF003_F002_F001_F000));
      directed_rows.push_back(csr_row(CSR_THR_HIGH, 64'hF003_F006_F005_F004));
      // Curve with 0 %, odd percentages, exactly 100 % and bytes above 100 %.
      directed_rows.push_back(csr_row(CSR_CURVE_0, 64'h65FF_6463_4232_2100));
      // Climb into saturation: spark drops once the count sits at the limit.
      repeat (8) directed_rows.push_back(tick_row(1'b1));
      // Lower the limit under the live count; high level must hold it.
      directed_rows.push_back(csr_row(CSR_THR_HIGH, 64'hF001_F006_F005_F004));
      directed_rows.push_back(tick_row(1'b1));
      // Edge in band 6: clamped percentage clears the counter.
      directed_rows.push_back(tick_row(1'b0));
      directed_rows.push_back(tick_row(1'b0));
      // Edge at zero fires a spark, then count to the new limit.
      repeat (3) directed_rows.push_back(tick_row(1'b1));
      // Thresholds out of order: the compare tree decides the band.
      directed_rows.push_back(csr_row(CSR_THR_LOW, 64'h0001_0005_0000_0004));
      repeat (2) directed_rows.push_back(tick_row(1'b0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            quiesce();
            csr_write(directed_rows[i].index, directed_rows[i].data);
         end else begin
            send_tick(directed_rows[i].level, directed_rows[i].pinned,
                      directed_rows[i].result);
         end
      end

      // Random phases: rewrite every register, then drive sensor waveforms of
      // alternating high and low runs sized to the phase's counter limit.
      foreach (phase_plan[p]) begin
         kind = phase_plan[p];
         quiesce();

         sorted = ($urandom_range(0, 3) != 0);
         acc    = 0;
         foreach (thr[k]) begin
            case (kind)
               PH_ZERO_THR: thr[k] = 0;
               PH_WIDE_THR: thr[k] = THR_MASK;
               default: begin
                  acc += $urandom_range(0, 6);
                  thr[k] = sorted ? acc : int'($urandom_range(0, 30));
               end
            endcase
            // Keep random junk in the slot bits above the threshold.
            slot = (SLOT_BITS'($urandom) & ~SLOT_BITS'(THR_MASK)) | SLOT_BITS'(thr[k]);
            bank[k / SLOTS_PER_REG][(k % SLOTS_PER_REG) * SLOT_BITS +: SLOT_BITS] = slot;
         end
         foreach (curve_word[c]) begin
            for (int b = 0; b < NUM_THR; b++)
               curve_word[c][b * BYTE_BITS +: BYTE_BITS] = ($urandom_range(0, 2) == 0) ?
                  BYTE_BITS'($urandom_range(0, 255)) : BYTE_BITS'($urandom_range(0, 100));
         end
         if (kind == PH_RESET_CFG) begin
            bank[0] = RESET_THR_LOW;
            bank[1] = RESET_THR_HIGH;
            curve_word = '{RESET_CURVE_0, RESET_CURVE_1, RESET_CURVE_2, RESET_CURVE_3};
         end
         // Walk every curve; junk above the select field must be ignored.
         sel_word = {$urandom, $urandom};
         sel_word[CURVE_SEL_BITS-1:0] = CURVE_SEL_BITS'(p % NUM_CURVES);

         csr_write(CSR_THR_LOW, bank[0]);
         csr_write(CSR_THR_HIGH, bank[1]);
         csr_write(CSR_CURVE_0, curve_word[0]);
         csr_write(CSR_CURVE_1, curve_word[1]);
         csr_write(CSR_CURVE_2, curve_word[2]);
         csr_write(CSR_CURVE_3, curve_word[3]);
         csr_write(CSR_CURVE_SEL, sel_word);

         no_idle = (kind == PH_WIDE_THR) || ($urandom_range(0, 3) == 0);

         if (kind == PH_WIDE_THR) begin
            // Back-to-back high run far under the widest limit; edges land in band 0.
            if (drive_level)
               emit_run(1'b0, 1);
            emit_run(1'b1, 30);
            emit_run(1'b0, 4);
            emit_run(1'b1, 2);
         end else begin
            case (kind)
               PH_ZERO_THR:  begin budget = 30; scale = 4;                        end
               PH_RESET_CFG: begin budget = 60; scale = 150;                      end
               default:      begin budget = 30; scale = 2 * thr[NUM_THR - 1] + 3; end
            endcase
            sent = 0;
            while (sent < budget) begin
               // Mostly full-length runs; now and then a short glitch.
               len = ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, 2)) :
                                                   int'($urandom_range(1, scale));
               emit_run(!drive_level, len);
               sent += len;
            end
         end
      end

      quiesce();
      if (!failed)
         $display("ignition_advance_tick_timer verification clean");
      else
         $display("ignition_advance_tick_timer verification failed");
      $finish;
   end

endmodule
